// File: sv/hctbp_pkg.sv
// Package for the Huffman code table bit packer.
// Request function codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package hctbp_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  localparam int SYMBOLS_DEF      = 256;
  localparam int MAX_CODE_LEN_DEF = 64;

  localparam int SYM_W      = 8;
  localparam int WORD_W     = 64;
  localparam int LEN_IN_W   = 7;
  localparam int TOTAL_W    = 48;
  localparam int S_DATA_W   = 80;
  localparam int M_DATA_W   = 56;

endpackage

// File: sv/huffman_code_table_bit_packer.sv
// Huffman code table bit packer: code table memories, packing stage and output byte emitter.
// Depends on hctbp_pkg.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries requests; tuser selects load, encode or flush.
//   Load writes one code table entry and gives no result.
//   Encode looks up the symbol's code and appends it to the bit accumulator;
//   each completed byte leaves on the master stream, the last one of the
//   request with tlast. Flush gives one result with the zero padded partial
//   byte (tuser low when there was none), the bit count, and tlast.
// Path: request, table read register, packing stage, emitter register, result.
// Throughput: one request per cycle while each encode yields at most one
//   byte and the receiver is ready. An encode yielding more bytes holds the
//   output emitter, one byte per cycle while tready is high; the table memory
//   read port is read once per request.
// Reset: all code lengths read as zero (per-entry valid bits), accumulator
//   and bit count cleared. Code words are undefined until loaded.
// Stall: while the receiver holds tready low the result holds; the packing
//   stage and then the input side stall behind it, nothing is dropped.

module huffman_code_table_bit_packer #(
  parameter int SYMBOLS      = hctbp_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // symbol[7:0], code_word[71:8], code_length[78:72], zero[79]
  input  logic [hctbp_pkg::S_DATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // packed_byte[7:0], total_bits[55:8]
  output logic [hctbp_pkg::M_DATA_W-1:0] m_axis_tdata,
  // byte_valid[0]
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  import hctbp_pkg::*;

  localparam int IDX_W = $clog2(SYMBOLS);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ACC_W = MAX_CODE_LEN + 7;
  localparam int SUM_W = $clog2(ACC_W + 1);
  localparam int NB_W  = SUM_W - 3;
  localparam int NB_MAX = ACC_W / 8;

  // request fields
  func_t                 in_func;
  logic [SYM_W-1:0]      in_symbol;
  logic [WORD_W-1:0]     in_word;
  logic [LEN_IN_W-1:0]   in_len;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_sym_ok;
  logic [LEN_W-1:0]      in_len_sat;
  logic                  in_accept;

  assign in_func   = func_t'(s_axis_tuser);
  assign in_symbol = s_axis_tdata[7:0];
  assign in_word   = s_axis_tdata[71:8];
  assign in_len    = s_axis_tdata[78:72];
  assign in_idx    = in_symbol[IDX_W-1:0];
  assign in_sym_ok = ({1'b0, in_symbol} < 9'(SYMBOLS));
  assign in_len_sat = (in_len > LEN_IN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : in_len[LEN_W-1:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // code table memories
  logic [MAX_CODE_LEN-1:0] word_mem [SYMBOLS];
  logic [LEN_W-1:0]        len_mem  [SYMBOLS];
  logic [SYMBOLS-1:0]      len_vld;
  logic [MAX_CODE_LEN-1:0] rd_word;
  logic [LEN_W-1:0]        rd_len;
  logic                    rd_vld;
  logic                    load_en;

  assign load_en = in_accept && (in_func == FUNC_LOAD) && in_sym_ok;

  always_ff @(posedge clk) begin
    if (load_en) begin
      word_mem[in_idx] <= in_word[MAX_CODE_LEN-1:0];
      len_mem[in_idx]  <= in_len_sat;
    end
    if (in_accept) begin
      rd_word <= word_mem[in_idx];
      rd_len  <= len_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (load_en) begin
      len_vld[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_vld <= len_vld[in_idx];
    end
  end

  // packing stage
  logic                 s1_valid;
  logic                 s1_flush;
  logic [6:0]           pending_bits;
  logic [2:0]           pending_count;
  logic [TOTAL_W-1:0]   bit_total;
  logic [LEN_W-1:0]     len_eff;
  logic [MAX_CODE_LEN-1:0] word_masked;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     residue;
  logic [SUM_W-1:0]     bit_sum;
  logic [NB_W-1:0]      nb;
  logic [TOTAL_W:0]     total_sum;
  logic                 s1_emit;
  logic                 s1_adv;

  assign len_eff = rd_vld ? rd_len : '0;

  always_comb begin
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      word_masked[i] = rd_word[i] && (i < int'(len_eff));
    end
  end

  assign acc       = ACC_W'(pending_bits) | ({7'd0, word_masked} << pending_count);
  assign bit_sum   = SUM_W'(pending_count) + SUM_W'(len_eff);
  assign nb        = bit_sum[SUM_W-1:3];
  assign residue   = acc >> {nb, 3'b000};
  assign total_sum = {1'b0, bit_total} + (TOTAL_W + 1)'(len_eff);
  assign s1_emit   = s1_flush || (nb != '0);

  // output emitter
  logic [ACC_W-1:0]   emit_buf;
  logic [NB_W-1:0]    emit_cnt;
  logic               emit_bvalid;
  logic [TOTAL_W-1:0] emit_total;
  logic               emit_free;
  logic               m_accept;

  assign m_accept  = m_axis_tvalid && m_axis_tready;
  assign emit_free = (emit_cnt == '0) || (m_axis_tready && (emit_cnt == NB_W'(1)));
  assign s1_adv    = s1_valid && (!s1_emit || emit_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= in_accept &&
                  ((in_func == FUNC_FLUSH) || ((in_func == FUNC_ENCODE) && in_sym_ok));
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_flush <= (in_func == FUNC_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      bit_total     <= '0;
    end else if (s1_adv) begin
      if (s1_flush) begin
        pending_bits  <= '0;
        pending_count <= '0;
        bit_total     <= '0;
      end else begin
        pending_bits  <= residue[6:0];
        pending_count <= bit_sum[2:0];
        bit_total     <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt <= '0;
    end else if (s1_adv && s1_emit) begin
      emit_cnt <= s1_flush ? NB_W'(1) : nb;
    end else if (m_accept) begin
      emit_cnt <= emit_cnt - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      if (s1_flush) begin
        emit_buf    <= (pending_count != '0) ? ACC_W'(pending_bits) : '0;
        emit_bvalid <= (pending_count != '0);
        emit_total  <= bit_total;
      end else begin
        emit_buf    <= acc;
        emit_bvalid <= 1'b1;
        emit_total  <= '0;
      end
    end else if (m_accept) begin
      emit_buf <= emit_buf >> 8;
    end
  end

  assign m_axis_tvalid   = (emit_cnt != '0);
  assign m_axis_tdata    = {emit_total, emit_buf[7:0]};
  assign m_axis_tuser[0] = emit_bvalid;
  assign m_axis_tlast    = (emit_cnt == NB_W'(1));

`ifndef SYNTHESIS
  a_emit_cnt_max: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= NB_W'(NB_MAX))
    else $error("emitter byte count above maximum");

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == 7'd0)
    else $error("stale bits above pending count");

  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_flush) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("flush did not produce a final result");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("packing stage lost a request");
`endif

endmodule
